@@ rtl/hsms_pkg.sv @@
`timescale 1ns / 1ps
// Package for the humidity sensor measure sequencer: codes, phase type,
// result struct, wait-time table and reading conversions. No dependencies.
package hsms_pkg;

    localparam int FUNC_W     = 2;
    localparam int CMD_W      = 8;
    localparam int DELAY_W    = 5;
    localparam int READING_W  = 15;
    localparam int WORD_W     = 16;
    localparam int RES_MODE_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 48;

    localparam logic [FUNC_W-1:0] FUNC_TRIG_H = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRIG_T = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POLL   = 2'd2;

    localparam logic [CMD_W-1:0] CMD_NONE      = 8'h00;
    localparam logic [CMD_W-1:0] CMD_MEAS_H    = 8'hF5;
    localparam logic [CMD_W-1:0] CMD_MEAS_T    = 8'hF3;
    localparam logic [CMD_W-1:0] CMD_READ_PREV = 8'hE0;

    localparam logic [DELAY_W-1:0] DELAY_DEFAULT = 5'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_COMBINED   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 1'd1;

    localparam logic [13:0] HUMID_SCALE  = 14'd12500;
    localparam logic [14:0] HUMID_OFFSET = 15'd600;
    localparam logic [14:0] TEMP_SCALE   = 15'd17572;
    localparam logic [14:0] TEMP_OFFSET  = 15'd4685;

    typedef enum logic [2:0]
    {
        PH_IDLE   = 3'd0,
        PH_TRIG_H = 3'd1,
        PH_TRIG_T = 3'd2,
        PH_READ_H = 3'd3,
        PH_READ_T = 3'd4
    } phase_t;

    typedef struct packed
    {
        logic                        busy_res;
        logic signed [READING_W-1:0] temperature;
        logic                        temp_valid;
        logic signed [READING_W-1:0] humidity;
        logic                        humid_valid;
        logic [DELAY_W-1:0]          next_delay;
        logic                        bus_read;
        logic [CMD_W-1:0]            command;
        logic                        trigger_rejected;
    } result_t;

    typedef struct packed
    {
        logic                  combined_mode;
        logic [RES_MODE_W-1:0] resolution_mode;
    } cfg_t;

    function automatic logic [DELAY_W-1:0] wait_ms(input logic [RES_MODE_W-1:0] mode);
        logic [DELAY_W-1:0] ms;
        case (mode)
            2'd0:    ms = 5'd23;
            2'd1:    ms = 5'd8;
            2'd2:    ms = 5'd12;
            default: ms = 5'd10;
        endcase
        return ms;
    endfunction

    function automatic logic [READING_W-1:0] humid_conv(input logic [WORD_W-1:0] v);
        logic [29:0] prod;
        prod = 30'(v) * 30'(HUMID_SCALE);
        return {1'b0, prod[29:16]} - HUMID_OFFSET;
    endfunction

    function automatic logic [READING_W-1:0] temp_conv(input logic [WORD_W-1:0] v);
        logic [30:0] prod;
        prod = 31'(v) * 31'(TEMP_SCALE);
        return prod[30:16] - TEMP_OFFSET;
    endfunction

endpackage

@@ rtl/hsms_step.sv @@
`timescale 1ns / 1ps
// Per-beat step logic: phase transition, command selection and reading
// conversion. Depends on hsms_pkg.
module hsms_step
(
    input  hsms_pkg::phase_t                      phase,
    input  hsms_pkg::cfg_t                        cfg,
    input  logic [hsms_pkg::FUNC_W-1:0]           func,
    input  logic                                  bus_ok,
    input  logic [hsms_pkg::WORD_W-1:0]           raw_word,
    input  logic                                  temp_ok,
    input  logic [hsms_pkg::WORD_W-1:0]           temp_word,
    output hsms_pkg::phase_t                      phase_next,
    output hsms_pkg::result_t                     result
);
    import hsms_pkg::*;

    logic [WORD_W-1:0]    t_src;
    logic [READING_W-1:0] h_val;
    logic [READING_W-1:0] t_val;

    assign t_src = (phase == PH_READ_T) ? raw_word : temp_word;
    assign h_val = humid_conv(raw_word);
    assign t_val = temp_conv(t_src);

    always_comb
    begin
        phase_next = phase;
        result     = '0;
        result.next_delay = DELAY_DEFAULT;
        if (func == FUNC_TRIG_H || func == FUNC_TRIG_T)
        begin
            if (phase == PH_IDLE)
                phase_next = (func == FUNC_TRIG_H) ? PH_TRIG_H : PH_TRIG_T;
            else
                result.trigger_rejected = 1'b1;
        end
        else if (func == FUNC_POLL)
        begin
            case (phase)
                PH_TRIG_H, PH_TRIG_T:
                begin
                    result.command = (phase == PH_TRIG_H) ? CMD_MEAS_H : CMD_MEAS_T;
                    if (bus_ok)
                    begin
                        phase_next = (phase == PH_TRIG_H) ? PH_READ_H : PH_READ_T;
                        result.next_delay = wait_ms(cfg.resolution_mode);
                    end
                    else
                        phase_next = PH_IDLE;
                end
                PH_READ_H:
                begin
                    result.bus_read = 1'b1;
                    if (bus_ok)
                    begin
                        result.humid_valid = 1'b1;
                        result.humidity    = h_val;
                        if (cfg.combined_mode)
                        begin
                            result.command = CMD_READ_PREV;
                            if (temp_ok)
                            begin
                                result.temp_valid  = 1'b1;
                                result.temperature = t_val;
                            end
                        end
                        phase_next = PH_IDLE;
                    end
                end
                PH_READ_T:
                begin
                    result.bus_read = 1'b1;
                    if (bus_ok)
                    begin
                        result.temp_valid  = 1'b1;
                        result.temperature = t_val;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        result.busy_res = (phase_next != PH_IDLE);
    end

endmodule

@@ rtl/humidity_sensor_measure_sequencer.sv @@
`timescale 1ns / 1ps
// Top level of the humidity sensor measure sequencer: input register, step
// logic, result register and configuration registers. Depends on hsms_pkg, hsms_step.

// One result beat per input beat. A beat is registered on input, passes the
// step logic (phase update and one constant multiply per reading) and lands
// in the result register. A new beat is taken every cycle while the output
// side keeps up. A result that is not taken holds, as does a full input register.
// Configuration writes are always accepted and apply to beats that reach the
// step logic afterwards.
module humidity_sensor_measure_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bus_ok, raw_word[15:0], temp_ok, temp_word[15:0], zero pad
    input  logic [hsms_pkg::S_DATA_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [hsms_pkg::FUNC_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // trigger_rejected, command[7:0], bus_read, next_delay[4:0], humid_valid,
    // humidity[14:0], temp_valid, temperature[14:0], busy_res
    output logic [hsms_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hsms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsms_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hsms_pkg::*;

    logic                in_valid_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic                bus_ok_reg;
    logic [WORD_W-1:0]   raw_word_reg;
    logic                temp_ok_reg;
    logic [WORD_W-1:0]   temp_word_reg;

    logic                out_valid_reg;
    result_t             out_reg;
    phase_t              phase_reg;
    cfg_t                cfg_reg;

    phase_t              phase_next;
    result_t             result_next;
    logic                out_free;
    logic                advance;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    hsms_step u_step
    (
        .phase      (phase_reg),
        .cfg        (cfg_reg),
        .func       (func_reg),
        .bus_ok     (bus_ok_reg),
        .raw_word   (raw_word_reg),
        .temp_ok    (temp_ok_reg),
        .temp_word  (temp_word_reg),
        .phase_next (phase_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            cfg_reg.combined_mode   <= 1'b1;
            cfg_reg.resolution_mode <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                phase_reg <= phase_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_COMBINED:   cfg_reg.combined_mode   <= cfg_data[0];
                    CFG_RESOLUTION: cfg_reg.resolution_mode <= cfg_data[RES_MODE_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            func_reg      <= s_tuser;
            bus_ok_reg    <= s_tdata[0];
            raw_word_reg  <= s_tdata[16:1];
            temp_ok_reg   <= s_tdata[17];
            temp_word_reg <= s_tdata[33:18];
        end
        if (advance)
            out_reg <= result_next;
    end

endmodule

@@ rtl/hsms_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the humidity sensor measure sequencer, bound to the
// top level. Depends on hsms_pkg.
module hsms_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [hsms_pkg::M_DATA_W-1:0]     m_tdata
);
    import hsms_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a rejected trigger never leaves the sequencer idle
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[47] && m_tdata[8:1] == CMD_NONE && !m_tdata[9])
        else $error("rejected trigger with idle sequencer or bus activity");

    // readings are zero unless flagged valid
    a_reading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15] || m_tdata[30:16] == '0)
                  && (m_tdata[31] || m_tdata[46:32] == '0))
        else $error("unflagged reading not zero");

    // a completed humidity reading ends the measurement
    a_humid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |-> m_tdata[9] && !m_tdata[47]
                                 && m_tdata[14:10] == DELAY_DEFAULT)
        else $error("humidity reading without read or while busy");

endmodule

bind humidity_sensor_measure_sequencer hsms_checker u_hsms_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/tb_humidity_sensor_measure_sequencer.sv @@
`timescale 1ns / 1ps
// Testbench for humidity_sensor_measure_sequencer: stream driver and sink with random
// gaps and a scoreboard class that predicts every result beat. Depends on hsms_pkg.
module tb_humidity_sensor_measure_sequencer;

    import hsms_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int ITEMS      = 1750;
    localparam int PHASE_LEN  = 200;
    // results come one per item; with the random gaps on each side a quiet
    // streak stays well under QUIET_LIMIT
    localparam int QUIET_LIMIT = 2000;

    class measure_predictor;
        phase_t            phase;
        logic              combined;
        logic [RES_MODE_W-1:0] res_mode;
        result_t           pending_results[$];
        int                errors;

        function new();
            phase    = PH_IDLE;
            combined = 1'b1;
            res_mode = '0;
            errors   = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_COMBINED)
                combined = val[0];
            else
                res_mode = val[RES_MODE_W-1:0];
        endfunction

        function logic [READING_W-1:0] to_centi_celsius(logic [WORD_W-1:0] v);
            int t;
            t = int'((32'(v) * 32'd17572) >> 16) - 4685;
            return t[READING_W-1:0];
        endfunction

        function void accept_event(logic [FUNC_W-1:0] fn, logic ok, logic [WORD_W-1:0] raw,
                                   logic tok, logic [WORD_W-1:0] tword);
            result_t r;
            int      h;
            r = '0;
            r.next_delay = DELAY_DEFAULT;
            if (fn == FUNC_TRIG_H || fn == FUNC_TRIG_T)
            begin
                if (phase == PH_IDLE)
                    phase = (fn == FUNC_TRIG_H) ? PH_TRIG_H : PH_TRIG_T;
                else
                    r.trigger_rejected = 1'b1;
            end
            else if (fn == FUNC_POLL)
            begin
                case (phase)
                    PH_TRIG_H, PH_TRIG_T:
                    begin
                        r.command = (phase == PH_TRIG_H) ? CMD_MEAS_H : CMD_MEAS_T;
                        if (ok)
                        begin
                            phase = (phase == PH_TRIG_H) ? PH_READ_H : PH_READ_T;
                            case (res_mode)
                                2'd0:    r.next_delay = 5'd23;
                                2'd1:    r.next_delay = 5'd8;
                                2'd2:    r.next_delay = 5'd12;
                                default: r.next_delay = 5'd10;
                            endcase
                        end
                        else
                            phase = PH_IDLE;
                    end
                    PH_READ_H:
                    begin
                        r.bus_read = 1'b1;
                        if (ok)
                        begin
                            h = int'((32'(raw) * 32'd12500) >> 16) - 600;
                            r.humid_valid = 1'b1;
                            r.humidity    = h[READING_W-1:0];
                            if (combined)
                            begin
                                r.command = CMD_READ_PREV;
                                if (tok)
                                begin
                                    r.temp_valid  = 1'b1;
                                    r.temperature = to_centi_celsius(tword);
                                end
                            end
                            phase = PH_IDLE;
                        end
                    end
                    PH_READ_T:
                    begin
                        r.bus_read = 1'b1;
                        if (ok)
                        begin
                            r.temp_valid  = 1'b1;
                            r.temperature = to_centi_celsius(raw);
                            phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            r.busy_res = (phase != PH_IDLE);
            pending_results.push_back(r);
        endfunction

        function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare("trigger_rejected", want.trigger_rejected, got.trigger_rejected);
            compare("command", want.command, got.command);
            compare("bus_read", want.bus_read, got.bus_read);
            compare("next_delay", want.next_delay, got.next_delay);
            compare("humid_valid", want.humid_valid, got.humid_valid);
            compare("humidity", want.humidity, got.humidity);
            compare("temp_valid", want.temp_valid, got.temp_valid);
            compare("temperature", want.temperature, got.temperature);
            compare("busy_res", want.busy_res, got.busy_res);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    measure_predictor pred;
    bit               no_gaps;
    int               events_sent;
    int               quiet_cycles;

    humidity_sensor_measure_sequencer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic send_event(input logic [FUNC_W-1:0] fn, input logic ok,
                              input logic [WORD_W-1:0] raw, input logic tok,
                              input logic [WORD_W-1:0] tword);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {6'd0, tword, tok, raw, ok};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pred.accept_event(fn, ok, raw, tok, tword);
        events_sent++;
    endtask

    task automatic send_random(input logic [FUNC_W-1:0] fn, input logic ok);
        send_event(fn, ok, pick_word(), 1'($urandom_range(0, 1)), pick_word());
    endtask

    // trigger, command poll (failure ends it), optional failed reads, final read
    task automatic run_measurement();
        logic [FUNC_W-1:0] trig;
        int                retries;
        trig = $urandom_range(0, 1) ? FUNC_TRIG_T : FUNC_TRIG_H;
        send_random(trig, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 4) == 0)
            send_random(2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0)
        begin
            send_random(FUNC_POLL, 1'b0);
            return;
        end
        send_random(FUNC_POLL, 1'b1);
        if ($urandom_range(0, 5) == 0)
            send_random(2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        retries = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (retries) send_random(FUNC_POLL, 1'b0);
        send_random(FUNC_POLL, 1'b1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pred.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        pred.set_config(idx, val);
    endtask

    task automatic configure(input logic comb, input logic [RES_MODE_W-1:0] res);
        write_reg(CFG_COMBINED, {1'($urandom_range(0, 1)), comb});
        write_reg(CFG_RESOLUTION, res);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            pred.check_result(result_t'(m_tdata));
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int stop_at;
        pred         = new();
        no_gaps      = 1'b0;
        events_sent  = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: combined on, longest wait
        send_event(FUNC_POLL,   1'b1, 16'h1234, 1'b1, 16'h4321);
        send_event(FUNC_SPARE,  1'b1, '1, 1'b1, '1);
        send_event(FUNC_TRIG_H, 1'b0, '0, 1'b0, '0);
        send_event(FUNC_TRIG_T, 1'b1, '1, 1'b1, '1);
        send_event(FUNC_POLL,   1'b1, '0, 1'b0, '0);
        send_event(FUNC_TRIG_H, 1'b0, '0, 1'b0, '0);
        send_event(FUNC_POLL,   1'b0, '1, 1'b1, '1);
        send_event(FUNC_POLL,   1'b1, '0, 1'b1, '0);
        send_event(FUNC_TRIG_T, 1'b0, '0, 1'b0, '0);
        send_event(FUNC_POLL,   1'b0, '0, 1'b0, '0);
        send_event(FUNC_TRIG_T, 1'b0, '0, 1'b0, '0);
        send_event(FUNC_POLL,   1'b1, '0, 1'b0, '0);
        send_event(FUNC_SPARE,  1'b0, '0, 1'b0, '0);
        send_event(FUNC_POLL,   1'b1, '1, 1'b0, '0);
        send_event(FUNC_TRIG_H, 1'b1, '0, 1'b0, '0);
        send_event(FUNC_POLL,   1'b1, '0, 1'b0, '0);
        send_event(FUNC_POLL,   1'b1, '1, 1'b0, '1);
        send_event(FUNC_TRIG_H, 1'b1, '0, 1'b0, '0);
        send_event(FUNC_POLL,   1'b1, '0, 1'b0, '0);
        send_event(FUNC_POLL,   1'b1, 16'h8000, 1'b1, '1);

        // every combination of the two registers turns up over eight phases
        ph = 0;
        while (events_sent < ITEMS)
        begin
            settle();
            configure(ph[0], 2'(3 - (ph / 2) % 4));
            no_gaps = (ph % 4 == 2);
            stop_at = events_sent + PHASE_LEN;
            while (events_sent < stop_at)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_random(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                else
                    run_measurement();
            end
            ph++;
        end
        settle();

        if (pred.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
